// ===== rtl/core/sdpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step/direction position tracker package
// Shared widths, constants, register indexes and the config, state and result types.
// ----------------------------------------------------------------------------
package sdpt_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ANGLE_W  = 12;
    localparam int unsigned WINDOW_W = 11;
    localparam int unsigned LIFT_W   = 9;
    localparam int unsigned CFG_IDX_W = 2;

    // Control byte bit positions.
    localparam int unsigned ROT_STEP_BIT  = 0;
    localparam int unsigned ROT_DIR_BIT   = 1;
    localparam int unsigned LIFT_STEP_BIT = 2;
    localparam int unsigned LIFT_DIR_BIT  = 3;

    // Status byte: active-low flags on an all-ones base.
    localparam logic [BYTE_W-1:0] STATUS_IDLE      = 8'hFF;
    localparam logic [BYTE_W-1:0] STATUS_IN_WINDOW = 8'hFE;
    localparam logic [BYTE_W-1:0] STATUS_AT_TOP    = 8'hFD;
    localparam logic [BYTE_W-1:0] STATUS_AT_BOTTOM = 8'hFB;

    // Angle in tenths of a degree.
    localparam logic [ANGLE_W:0] FULL_TURN      = 13'd3600;
    localparam logic [ANGLE_W:0] ANGLE_STEP     = 13'd9;
    localparam logic [ANGLE_W:0] TURN_LESS_STEP = 13'd3591;
    localparam logic [ANGLE_W-1:0] CCW_SNAP_BELOW = 12'd10;
    localparam logic [ANGLE_W-1:0] CW_SNAP_FROM   = 12'd3590;
    localparam logic [ANGLE_W-1:0] ANGLE_FULL     = 12'd3600;
    localparam logic [ANGLE_W-1:0] ANGLE_ZERO     = 12'd0;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_BOTTOM    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_INTERLOCK = 2'd3;

    // Register reset values.
    localparam logic [ANGLE_W-1:0]  START_ANGLE_RST    = 12'd720;
    localparam logic [WINDOW_W-1:0] WINDOW_WIDTH_RST   = 11'd200;
    localparam logic [LIFT_W-1:0]   LIFT_BOTTOM_RST    = 9'd400;
    localparam logic [LIFT_W-1:0]   LIFT_INTERLOCK_RST = 9'd209;

    typedef struct packed {
        logic [WINDOW_W-1:0] window_width;
        logic [LIFT_W-1:0]   lift_bottom;
        logic [LIFT_W-1:0]   lift_interlock;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  previous_byte;
        logic               primed;
        logic [ANGLE_W-1:0] angle;
        logic [LIFT_W-1:0]  lift;
        logic               window_reported;
        logic               top_reported;
        logic               bottom_reported;
    } track_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  status_byte;
        logic               send_now;
        logic [ANGLE_W-1:0] angle_now;
        logic [LIFT_W-1:0]  lift_now;
        logic               step_dropped;
    } result_t;

endpackage

// ===== rtl/core/sdpt_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step/direction position tracker update logic
// Decodes one control byte against the tracker state and produces the next
// state and the result beat.
// ----------------------------------------------------------------------------
module sdpt_step
    import sdpt_pkg::*;
(
    input  track_state_t      state,
    input  cfg_t              cfg,
    input  logic [BYTE_W-1:0] control_byte,
    output track_state_t      state_next,
    output result_t           result
);

    logic               rot_fall;
    logic               lift_fall;
    logic               ccw;
    logic [ANGLE_W:0]   angle_raw;
    logic [ANGLE_W:0]   angle_wrap;
    logic [ANGLE_W-1:0] angle_step;
    logic               in_window;
    logic [ANGLE_W-1:0] window_low;

    assign rot_fall  = state.previous_byte[ROT_STEP_BIT] & ~control_byte[ROT_STEP_BIT];
    assign lift_fall = state.previous_byte[LIFT_STEP_BIT] & ~control_byte[LIFT_STEP_BIT];
    assign ccw       = control_byte[ROT_DIR_BIT];

    always_comb
    begin
        if (ccw)
        begin
            if ({1'b0, state.angle} < ANGLE_STEP)
            begin
                angle_raw = {1'b0, state.angle} + TURN_LESS_STEP;
            end
            else
            begin
                angle_raw = {1'b0, state.angle} - ANGLE_STEP;
            end
        end
        else
        begin
            angle_raw = {1'b0, state.angle} + ANGLE_STEP;
        end
        if (angle_raw > FULL_TURN)
        begin
            angle_wrap = angle_raw - FULL_TURN;
        end
        else
        begin
            angle_wrap = angle_raw;
        end
    end

    assign angle_step = angle_wrap[ANGLE_W-1:0];
    assign window_low = ANGLE_FULL - {1'b0, cfg.window_width};
    assign in_window  = (angle_step <= {1'b0, cfg.window_width}) || (angle_step >= window_low);

    always_comb
    begin
        state_next          = state;
        result.status_byte  = STATUS_IDLE;
        result.send_now     = 1'b0;
        result.step_dropped = 1'b0;

        if (!state.primed)
        begin
            state_next.primed        = 1'b1;
            state_next.previous_byte = control_byte;
        end
        else if (rot_fall)
        begin
            // A dropped step leaves the whole byte without effect.
            if (state.lift >= cfg.lift_interlock)
            begin
                result.step_dropped = 1'b1;
            end
            else
            begin
                state_next.angle = angle_step;
                if (in_window)
                begin
                    result.status_byte = STATUS_IN_WINDOW;
                    if (!state.window_reported)
                    begin
                        result.send_now            = 1'b1;
                        state_next.window_reported = 1'b1;
                    end
                    if (ccw && (angle_step < CCW_SNAP_BELOW))
                    begin
                        state_next.angle = ANGLE_FULL;
                    end
                    if (!ccw && (angle_step >= CW_SNAP_FROM))
                    begin
                        state_next.angle = ANGLE_ZERO;
                    end
                end
                else
                begin
                    state_next.window_reported = 1'b0;
                end
                state_next.previous_byte = control_byte;
            end
        end
        else
        begin
            if (lift_fall)
            begin
                if (control_byte[LIFT_DIR_BIT])
                begin
                    if (state.lift >= cfg.lift_bottom)
                    begin
                        state_next.lift    = cfg.lift_bottom;
                        result.status_byte = STATUS_AT_BOTTOM;
                        if (!state.bottom_reported)
                        begin
                            result.send_now            = 1'b1;
                            state_next.bottom_reported = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next.lift            = state.lift + 1'b1;
                        state_next.bottom_reported = 1'b0;
                    end
                end
                else
                begin
                    if (state.lift == '0)
                    begin
                        result.status_byte = STATUS_AT_TOP;
                        if (!state.top_reported)
                        begin
                            result.send_now         = 1'b1;
                            state_next.top_reported = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next.lift         = state.lift - 1'b1;
                        state_next.top_reported = 1'b0;
                    end
                end
            end
            state_next.previous_byte = control_byte;
        end

        result.angle_now = state_next.angle;
        result.lift_now  = state_next.lift;
    end

endmodule

// ===== rtl/core/step_dir_position_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step/direction position tracker
// Counts rotary and lift steps from control bytes and reports window and
// end-stop status.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     in_valid/in_ready    control_byte
//  output    out_valid/out_ready  status_byte, send_now, angle_now, lift_now,
//                                 step_dropped
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  A beat is registered at the input and then processed into the output
//  register, which offers its result. One beat per cycle is sustained while
//  the output is not stalled; a stalled output register holds its beat and
//  the input stage backs up behind it, two beats deep.
//  Reset clears the valid flags, presets the registers and tracker state, but
//  not the input byte and result data; cfg_ready is always high.
// ----------------------------------------------------------------------------
module step_dir_position_tracker_top
    import sdpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    control_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    status_byte,
    output logic                 send_now,
    output logic [ANGLE_W-1:0]   angle_now,
    output logic [LIFT_W-1:0]    lift_now,
    output logic                 step_dropped,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               out_valid_reg;
    result_t            result_reg;
    result_t            result_next;
    track_state_t       state_reg;
    track_state_t       state_next;
    cfg_t               cfg_reg;
    logic               advance;
    logic               cfg_write;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    sdpt_step u_step (
        .state        (state_reg),
        .cfg          (cfg_reg),
        .control_byte (in_byte_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
            cfg_reg.window_width       <= WINDOW_WIDTH_RST;
            cfg_reg.lift_bottom        <= LIFT_BOTTOM_RST;
            cfg_reg.lift_interlock     <= LIFT_INTERLOCK_RST;
            state_reg.previous_byte    <= '0;
            state_reg.primed           <= 1'b0;
            state_reg.angle            <= START_ANGLE_RST;
            state_reg.lift             <= '0;
            state_reg.window_reported  <= 1'b0;
            state_reg.top_reported     <= 1'b0;
            state_reg.bottom_reported  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // Writes only come while idle, but the block does not enforce it; a start angle write reloads the angle.
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_START_ANGLE:    state_reg.angle        <= cfg_data[ANGLE_W-1:0];
                    REG_WINDOW_WIDTH:   cfg_reg.window_width   <= cfg_data[WINDOW_W-1:0];
                    REG_LIFT_BOTTOM:    cfg_reg.lift_bottom    <= cfg_data[LIFT_W-1:0];
                    REG_LIFT_INTERLOCK: cfg_reg.lift_interlock <= cfg_data[LIFT_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= control_byte;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status_byte  = result_reg.status_byte;
    assign send_now     = result_reg.send_now;
    assign angle_now    = result_reg.angle_now;
    assign lift_now     = result_reg.lift_now;
    assign step_dropped = result_reg.step_dropped;

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed beat did not reach the output register");

    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked output");

    a_send_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && send_now) |-> (status_byte != STATUS_IDLE))
        else $error("status sent with no flag lowered");

    a_drop_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && step_dropped) |-> (!send_now && status_byte == STATUS_IDLE))
        else $error("dropped step produced a status report");

endmodule
